>>> design/post_pkg.sv
// Package for the position ordered slot table: transaction types, operation
// and status codes, back-end states and the group priority encoder.
// Depends on nothing; every other design file but post_ram imports it.
package post_pkg;

	// Function codes carried in the request transaction.
	localparam logic [2:0] FN_INSERT = 3'd0;
	localparam logic [2:0] FN_REMOVE = 3'd1;
	localparam logic [2:0] FN_QUERY  = 3'd2;
	localparam logic [2:0] FN_HEAD   = 3'd3;
	localparam logic [2:0] FN_STEP   = 3'd4;

	// Status codes returned in the response transaction.
	localparam logic [1:0] STAT_OK          = 2'd0;
	localparam logic [1:0] STAT_OCCUPIED    = 2'd1;
	localparam logic [1:0] STAT_EMPTY       = 2'd2;
	localparam logic [1:0] STAT_TABLE_EMPTY = 2'd3;

	// The occupancy bitmap is scanned one group of this many slots at a time.
	localparam int GROUP_BITS     = 32;
	localparam int GROUP_IDX_BITS = 5;

	// Depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic [2:0]  func;
		logic [5:0]  position;
		logic [31:0] write_data;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        present;
		logic [31:0] read_data;
		logic [5:0]  found_position;
		logic        has_more;
	} result_t;

	typedef enum logic [2:0] {
		OP_INSERT,
		OP_REMOVE,
		OP_QUERY,
		OP_HEAD,
		OP_STEP,
		OP_NONE
	} op_t;

	// Classified command as handed from the front to the back.
	typedef struct packed {
		op_t         op;
		logic [5:0]  pos;
		logic        in_range;
		logic [6:0]  next_pos;
		logic        next_valid;
		logic [31:0] wdata;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EXEC,
		BK_SCAN,
		BK_DONE
	} bk_state_t;

	// Index of the lowest set bit of a group; zero when no bit is set.
	function automatic logic [GROUP_IDX_BITS-1:0] lowest_set(logic [GROUP_BITS-1:0] v);
		logic [GROUP_IDX_BITS-1:0] r;
		r = '0;
		for (int i = GROUP_BITS - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = GROUP_IDX_BITS'(i);
			end
		end
		return r;
	endfunction

endpackage

>>> design/post_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module post_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> design/post_front.sv
// Front end: accepts request transactions, classifies the function code and
// checks the position against the table size. Depends on post_pkg.
module post_front #(
	parameter int SLOTS = 64
) (
	input  logic          req_valid,
	output logic          req_stall,
	input  post_pkg::item_t req,
	input  logic          q_full,
	output logic          q_push,
	output post_pkg::cmd_t  q_cmd
);
	import post_pkg::*;

	op_t op;

	assign req_stall = q_full;
	assign q_push    = req_valid & ~q_full;

	always_comb begin
		case (req.func)
			FN_INSERT: op = OP_INSERT;
			FN_REMOVE: op = OP_REMOVE;
			FN_QUERY:  op = OP_QUERY;
			FN_HEAD:   op = OP_HEAD;
			FN_STEP:   op = OP_STEP;
			default:   op = OP_NONE;
		endcase
	end

	always_comb begin
		q_cmd.op         = op;
		q_cmd.pos        = req.position;
		q_cmd.in_range   = (int'(req.position) < SLOTS);
		q_cmd.next_pos   = 7'(req.position) + 7'd1;
		q_cmd.next_valid = (int'(req.position) + 1 < SLOTS);
		q_cmd.wdata      = req.write_data;
	end

endmodule

>>> design/post_queue.sv
// Short command queue between the front and the back end.
// Depends on post_pkg for the command type and the queue depth.
module post_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  post_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output post_pkg::cmd_t head,
	output logic           empty
);
	import post_pkg::*;

	localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           entry_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	assign full  = (count_q == QCW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/post_back.sv
// Back end: executes classified commands against the occupancy bitmap and the
// slot data RAM, scans for occupied slots and registers the response.
// Depends on post_pkg and post_ram.
module post_back #(
	parameter int SLOTS     = 64,
	parameter int DATA_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  post_pkg::cmd_t    q_head,
	output logic              q_pop,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output post_pkg::result_t rsp
);
	import post_pkg::*;

	localparam int NGROUP = (SLOTS + GROUP_BITS - 1) / GROUP_BITS;
	localparam int GIW    = (NGROUP > 1) ? $clog2(NGROUP) : 1;
	localparam int IW     = $clog2(SLOTS);

	bk_state_t state_q, state_d;
	cmd_t      cmd_q;
	result_t   res_q, res_d;
	result_t   rsp_q;
	logic      rsp_valid_q;

	logic [GIW-1:0]            scan_grp_q, scan_grp_d;
	logic [GROUP_IDX_BITS-1:0] scan_bit_q, scan_bit_d;
	logic                      scan_first_q, scan_first_d;

	logic [GROUP_BITS-1:0]     occ_q [NGROUP];
	logic [GIW-1:0]            occ_rd_grp;
	logic [GROUP_BITS-1:0]     occ_word;
	logic [GROUP_BITS-1:0]     start_mask;
	logic [GROUP_BITS-1:0]     masked;
	logic                      hit_any;
	logic [GROUP_IDX_BITS-1:0] hit_bit;
	logic                      scan_last;
	logic [GIW-1:0]            pos_grp;
	logic [GROUP_IDX_BITS-1:0] pos_bit;
	logic                      slot_full;
	logic                      occ_we;
	logic                      occ_val;
	logic                      out_load;

	logic                 ram_we;
	logic                 ram_re;
	logic [IW-1:0]        ram_raddr;
	logic [DATA_BITS-1:0] ram_rdata;

	post_ram #(
		.WIDTH (DATA_BITS),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IW'(cmd_q.pos)),
		.wdata (DATA_BITS'(cmd_q.wdata)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign pos_grp    = GIW'(cmd_q.pos >> GROUP_IDX_BITS);
	assign pos_bit    = cmd_q.pos[GROUP_IDX_BITS-1:0];
	assign occ_rd_grp = (state_q == BK_SCAN) ? scan_grp_q : pos_grp;
	assign occ_word   = occ_q[occ_rd_grp];
	assign slot_full  = cmd_q.in_range & occ_word[pos_bit];

	// Only the first group of a scan is trimmed below the start position.
	assign start_mask = scan_first_q ? ({GROUP_BITS{1'b1}} << scan_bit_q) : '1;
	assign masked     = occ_word & start_mask;
	assign hit_any    = |masked;
	assign hit_bit    = lowest_set(masked);
	assign scan_last  = (scan_grp_q == GIW'(NGROUP - 1));
	assign out_load   = (state_q == BK_DONE) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				case (cmd_q.op)
					OP_HEAD: state_d = BK_SCAN;
					OP_STEP: state_d = cmd_q.next_valid ? BK_SCAN : BK_DONE;
					default: state_d = BK_DONE;
				endcase
			end
			BK_SCAN: begin
				if (hit_any || scan_last) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_load) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop        = 1'b0;
		res_d        = res_q;
		scan_grp_d   = scan_grp_q;
		scan_bit_d   = scan_bit_q;
		scan_first_d = scan_first_q;
		occ_we       = 1'b0;
		occ_val      = 1'b0;
		ram_we       = 1'b0;
		ram_re       = 1'b0;
		ram_raddr    = IW'(cmd_q.pos);
		case (state_q)
			BK_IDLE: begin
				q_pop = !q_empty;
				res_d = '0;
			end
			BK_EXEC: begin
				case (cmd_q.op)
					OP_INSERT: begin
						if (!cmd_q.in_range || occ_word[pos_bit]) begin
							res_d.status = STAT_OCCUPIED;
						end else begin
							occ_we  = 1'b1;
							occ_val = 1'b1;
							ram_we  = 1'b1;
						end
					end
					OP_REMOVE: begin
						if (!slot_full) begin
							res_d.status = STAT_EMPTY;
						end else begin
							occ_we = 1'b1;
						end
					end
					OP_QUERY: begin
						res_d.present = slot_full;
						ram_re        = cmd_q.in_range;
					end
					OP_HEAD: begin
						scan_grp_d   = '0;
						scan_bit_d   = '0;
						scan_first_d = 1'b1;
					end
					OP_STEP: begin
						res_d.present = slot_full;
						res_d.status  = slot_full ? STAT_OK : STAT_EMPTY;
						ram_re        = cmd_q.in_range;
						scan_grp_d    = GIW'(cmd_q.next_pos >> GROUP_IDX_BITS);
						scan_bit_d    = cmd_q.next_pos[GROUP_IDX_BITS-1:0];
						scan_first_d  = 1'b1;
					end
					default: begin
						res_d = '0;
					end
				endcase
			end
			BK_SCAN: begin
				if (hit_any) begin
					res_d.found_position = 6'({scan_grp_q, hit_bit});
					res_d.has_more       = 1'b1;
					if (cmd_q.op == OP_HEAD) begin
						res_d.present = 1'b1;
						ram_re        = 1'b1;
						ram_raddr     = IW'({scan_grp_q, hit_bit});
					end
				end else if (scan_last) begin
					if (cmd_q.op == OP_HEAD) begin
						res_d.status = STAT_TABLE_EMPTY;
					end
				end else begin
					scan_grp_d   = scan_grp_q + 1'b1;
					scan_first_d = 1'b0;
				end
			end
			default: begin
				res_d = res_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			rsp_valid_q <= 1'b0;
			for (int g = 0; g < NGROUP; g++) begin
				occ_q[g] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (occ_we) begin
				occ_q[pos_grp][pos_bit] <= occ_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		res_q        <= res_d;
		scan_grp_q   <= scan_grp_d;
		scan_bit_q   <= scan_bit_d;
		scan_first_q <= scan_first_d;
		if (out_load) begin
			rsp_q.status         <= res_q.status;
			rsp_q.present        <= res_q.present;
			rsp_q.read_data      <= res_q.present ? 32'(ram_rdata) : '0;
			rsp_q.found_position <= res_q.found_position;
			rsp_q.has_more       <= res_q.has_more;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCAN) |-> (int'(scan_grp_q) < NGROUP))
		else $error("scan group beyond the occupancy bitmap");

	a_pop_exec: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == BK_EXEC))
		else $error("popped command not executed in the next cycle");

	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("slot RAM written and read in the same cycle");

	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == STAT_TABLE_EMPTY)
		|-> (!rsp_q.has_more && !rsp_q.present))
		else $error("empty-table response carries a position or data");

	a_present_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.present) |-> (rsp_q.status == STAT_OK))
		else $error("present slot reported with an error status");

endmodule

>>> design/position_ordered_slot_table_unit.sv
// Top level of the position ordered slot table: front end, command queue and
// back end. Depends on post_pkg, post_front, post_queue and post_back.
//
//  Channel  Signals                   Carries
//  req      req_valid, req_stall, req  func, position, write_data (item_t)
//  rsp      rsp_valid, rsp_stall, rsp  status, present, read_data,
//                                      found_position, has_more (result_t)
//
// The back end works on one command at a time: insert, remove, query and
// unused codes pass through the IDLE, EXEC and DONE states; head and step
// also scan the 32-slot occupancy groups, one group a cycle: 1 to
// ceil(SLOTS/32) groups for head, 0 to ceil(SLOTS/32) for step.
// Reset clears the occupancy bitmap at once; slot data is not cleared.
// The queue holds two requests while the back end is busy; a held response
// stalls the back end, and requests are still taken until the queue is full.
module position_ordered_slot_table_unit #(
	parameter int SLOTS     = 64,
	parameter int DATA_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  post_pkg::item_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output post_pkg::result_t rsp
);
	import post_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_empty;
	cmd_t q_cmd;
	cmd_t q_head;

	post_front #(
		.SLOTS (SLOTS)
	) u_front (
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	post_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	post_back #(
		.SLOTS     (SLOTS),
		.DATA_BITS (DATA_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule
